FILE: rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants for the sorted timer queue
// Command and result records, slot state codes and engine states.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int QUEUE_W    = 3;
    localparam int DATA_W     = 32;
    localparam logic [DATA_W-1:0] NO_DEADLINE = '1;

    // command codes on the mode field
    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_ARM   = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    // reply status codes
    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_FULL    = 2'd1,
        STS_BAD     = 2'd2,
        STS_UNUSED3 = 2'd3
    } status_t;

    // per-slot state
    typedef enum logic [1:0] {
        SS_UNUSED = 2'd0,
        SS_ALLOC  = 2'd1,
        SS_RUN    = 2'd2,
        SS_RSVD   = 2'd3
    } slot_st_t;

    // engine sequencer states
    typedef enum logic [2:0] {
        EN_IDLE,
        EN_WALK_NEXT,
        EN_WALK_DL,
        EN_LINK2,
        EN_TICK_EVAL
    } eng_st_t;

    typedef struct packed {
        op_t                op;
        logic [SLOT_W-1:0]  slot;
        logic [DATA_W-1:0]  delay;
        logic [DATA_W-1:0]  payload;
        logic [QUEUE_W-1:0] dest;
    } cmd_t;

    typedef struct packed {
        logic               kind;
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [DATA_W-1:0]  data;
        logic [QUEUE_W-1:0] queue;
        logic               last;
    } res_t;

endpackage

FILE: rtl/stq_front.sv
// ----------------------------------------------------------------------------
// stq_front: command intake
// Accepts command beats, decodes the mode and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module stq_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    in_mode,
    input  logic [71:0]   in_data,
    output logic          cmd_valid,
    output stq_pkg::cmd_t cmd,
    input  logic          cmd_pop
);
    import stq_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       in_cmd;
    logic       push;

    // unpack and classify the incoming beat
    always_comb begin
        in_cmd.op      = op_t'(in_mode);
        in_cmd.slot    = in_data[4:0];
        in_cmd.delay   = in_data[36:5];
        in_cmd.payload = in_data[68:37];
        in_cmd.dest    = in_data[71:69];
    end

    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: rtl/stq_engine.sv
// ----------------------------------------------------------------------------
// stq_engine: timer list engine
// Executes commands on the slot pool and walks the sorted list for arm/tick.
// ----------------------------------------------------------------------------
module stq_engine (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    input  stq_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          out_valid,
    output stq_pkg::res_t out,
    input  logic          out_ready
);
    import stq_pkg::*;

    // slot storage
    logic [DATA_W-1:0]  dl_mem   [SLOT_COUNT];
    logic [DATA_W-1:0]  pay_mem  [SLOT_COUNT];
    logic [QUEUE_W-1:0] dst_mem  [SLOT_COUNT];
    logic [SLOT_W-1:0]  nxt_mem  [SLOT_COUNT];
    logic [DATA_W-1:0]  rd_dl, rd_pay;
    logic [QUEUE_W-1:0] rd_dst;
    logic [SLOT_W-1:0]  rd_nxt;

    slot_st_t           sst_reg  [SLOT_COUNT];

    eng_st_t            st_reg, st_next;
    logic [DATA_W-1:0]  tick_reg, tick_next;
    logic [DATA_W-1:0]  early_reg, early_next;
    logic [CNT_W-1:0]   run_reg, run_next;
    logic [SLOT_W-1:0]  head_reg, head_next;
    logic [SLOT_W-1:0]  id_reg, id_next;
    logic [DATA_W-1:0]  ndl_reg, ndl_next;
    logic [SLOT_W-1:0]  prev_reg, prev_next;
    logic [SLOT_W-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    res_t               pres_reg, pres_next;
    logic               ov_reg, ov_next;
    res_t               ores_reg, ores_next;

    // memory port controls
    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic               we_data;
    logic [SLOT_W-1:0]  wa_data;
    logic [DATA_W-1:0]  wd_dl;
    logic               we_nxt;
    logic [SLOT_W-1:0]  wa_nxt, wd_nxt;
    logic               sst_we;
    logic [SLOT_W-1:0]  sst_wa;
    slot_st_t           sst_wd;

    logic               out_free;
    logic               free_found;
    logic [SLOT_W-1:0]  free_idx;
    logic [DATA_W-1:0]  arm_dl;
    logic               due;

    assign out_free  = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out       = ores_reg;
    assign arm_dl    = tick_reg + cmd.delay;
    assign due       = (idx_reg < run_reg) && (rd_dl <= tick_reg);

    // lowest unused slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
            if (sst_reg[k] == SS_UNUSED) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(k);
            end
        end
    end

    // sequencer
    always_comb begin
        st_next    = st_reg;
        tick_next  = tick_reg;
        early_next = early_reg;
        run_next   = run_reg;
        head_next  = head_reg;
        id_next    = id_reg;
        ndl_next   = ndl_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        pres_next  = pres_reg;
        ov_next    = ov_reg && !out_ready;
        ores_next  = ores_reg;
        cmd_pop    = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = head_reg;
        we_data    = 1'b0;
        wa_data    = cmd.slot;
        wd_dl      = arm_dl;
        we_nxt     = 1'b0;
        wa_nxt     = id_reg;
        wd_nxt     = head_reg;
        sst_we     = 1'b0;
        sst_wa     = cmd.slot;
        sst_wd     = SS_ALLOC;

        unique case (st_reg)
            EN_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop       = 1'b1;
                    ores_next     = '0;
                    ores_next.last = 1'b1;
                    ores_next.slot = cmd.slot;
                    unique case (cmd.op)
                        OP_ALLOC: begin
                            ov_next = 1'b1;
                            if (free_found) begin
                                sst_we         = 1'b1;
                                sst_wa         = free_idx;
                                sst_wd         = SS_ALLOC;
                                ores_next.slot = free_idx;
                            end else begin
                                ores_next.status = STS_FULL;
                                ores_next.slot   = '0;
                            end
                        end
                        OP_FREE: begin
                            ov_next = 1'b1;
                            if (sst_reg[cmd.slot] == SS_RUN) begin
                                ores_next.status = STS_BAD;
                            end else begin
                                sst_we = 1'b1;
                                sst_wd = SS_UNUSED;
                            end
                        end
                        OP_ARM: begin
                            ov_next = 1'b1;
                            if (sst_reg[cmd.slot] != SS_ALLOC) begin
                                ores_next.status = STS_BAD;
                            end else begin
                                sst_we   = 1'b1;
                                sst_wd   = SS_RUN;
                                we_data  = 1'b1;
                                id_next  = cmd.slot;
                                ndl_next = arm_dl;
                                // empty list or new earliest: link at head
                                if (run_reg == '0 || arm_dl <= early_reg) begin
                                    we_nxt     = 1'b1;
                                    wa_nxt     = cmd.slot;
                                    wd_nxt     = head_reg;
                                    head_next  = cmd.slot;
                                    early_next = arm_dl;
                                    run_next   = run_reg + 1'b1;
                                end else begin
                                    prev_next = head_reg;
                                    idx_next  = CNT_W'(1);
                                    rd_en     = 1'b1;
                                    rd_addr   = head_reg;
                                    st_next   = EN_WALK_NEXT;
                                end
                            end
                        end
                        OP_TICK: begin
                            tick_next = tick_reg + 1'b1;
                            if (early_reg <= tick_next) begin
                                cur_next  = head_reg;
                                idx_next  = '0;
                                pend_next = 1'b0;
                                rd_en     = 1'b1;
                                rd_addr   = head_reg;
                                st_next   = EN_TICK_EVAL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            EN_WALK_NEXT: begin
                if (idx_reg == run_reg) begin
                    // end of list: append
                    we_nxt   = 1'b1;
                    wa_nxt   = prev_reg;
                    wd_nxt   = id_reg;
                    run_next = run_reg + 1'b1;
                    st_next  = EN_IDLE;
                end else begin
                    cur_next = rd_nxt;
                    rd_en    = 1'b1;
                    rd_addr  = rd_nxt;
                    st_next  = EN_WALK_DL;
                end
            end
            EN_WALK_DL: begin
                if (ndl_reg <= rd_dl) begin
                    we_nxt  = 1'b1;
                    wa_nxt  = prev_reg;
                    wd_nxt  = id_reg;
                    st_next = EN_LINK2;
                end else begin
                    prev_next = cur_reg;
                    idx_next  = idx_reg + 1'b1;
                    rd_en     = 1'b1;
                    rd_addr   = cur_reg;
                    st_next   = EN_WALK_NEXT;
                end
            end
            EN_LINK2: begin
                we_nxt   = 1'b1;
                wa_nxt   = id_reg;
                wd_nxt   = cur_reg;
                run_next = run_reg + 1'b1;
                st_next  = EN_IDLE;
            end
            EN_TICK_EVAL: begin
                if (!pend_reg || out_free) begin
                    if (pend_reg) begin
                        ov_next        = 1'b1;
                        ores_next      = pres_reg;
                        ores_next.last = !due;
                    end
                    if (due) begin
                        pend_next        = 1'b1;
                        pres_next.kind   = 1'b1;
                        pres_next.status = STS_OK;
                        pres_next.slot   = cur_reg;
                        pres_next.data   = rd_pay;
                        pres_next.queue  = rd_dst;
                        pres_next.last   = 1'b0;
                        sst_we           = 1'b1;
                        sst_wa           = cur_reg;
                        sst_wd           = SS_ALLOC;
                        idx_next         = idx_reg + 1'b1;
                        cur_next         = rd_nxt;
                        rd_en            = 1'b1;
                        rd_addr          = rd_nxt;
                    end else begin
                        pend_next  = 1'b0;
                        run_next   = run_reg - idx_reg;
                        head_next  = cur_reg;
                        early_next = (run_reg != idx_reg) ? rd_dl : NO_DEADLINE;
                        st_next    = EN_IDLE;
                    end
                end
            end
            default: st_next = EN_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= EN_IDLE;
            tick_reg  <= '0;
            early_reg <= NO_DEADLINE;
            run_reg   <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            st_reg    <= st_next;
            tick_reg  <= tick_next;
            early_reg <= early_next;
            run_reg   <= run_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        id_reg   <= id_next;
        ndl_reg  <= ndl_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        idx_reg  <= idx_next;
        pres_reg <= pres_next;
        ores_reg <= ores_next;
    end

    // slot state flops
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                sst_reg[k] <= SS_UNUSED;
            end
        end else if (sst_we) begin
            sst_reg[sst_wa] <= sst_wd;
        end
    end

    // slot memories
    always_ff @(posedge aclk) begin
        if (we_data) begin
            dl_mem[wa_data]  <= wd_dl;
            pay_mem[wa_data] <= cmd.payload;
            dst_mem[wa_data] <= cmd.dest;
        end
        if (we_nxt) begin
            nxt_mem[wa_nxt] <= wd_nxt;
        end
        if (rd_en) begin
            rd_dl  <= dl_mem[rd_addr];
            rd_pay <= pay_mem[rd_addr];
            rd_dst <= dst_mem[rd_addr];
            rd_nxt <= nxt_mem[rd_addr];
        end
    end

endmodule

FILE: rtl/sorted_timer_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue_top: deadline-sorted timer slot pool
// Command intake queue in front of a list engine with a registered output.
//
//  channel | dir | tuser     | tdata                                 | tlast
//  s_      | in  | mode      | slot_id, delay, payload, destination  | -
//  m_      | out | kind      | status, slot_number, expiry_data,     | last
//          |     |           | target_queue                          |
//
// Allocate and free complete in the idle state, as does arm when the slot
// goes to the head; else arm walks the list entry by entry (next pointer,
// then deadline, through the registered slot memory port). A tick with
// nothing due completes in the idle state; else the engine reports each
// expired slot in list order. Reset is synchronous, active low, and empties
// the pool. Either side may stall; the intake queue holds two beats.
// ----------------------------------------------------------------------------
module sorted_timer_queue_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // mode
    input  logic [71:0] s_tdata,   // slot_id, delay, payload, destination
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,   // kind
    output logic [47:0] m_tdata,   // status, slot_number, expiry_data, target_queue
    output logic        m_tlast
);
    import stq_pkg::*;

    logic cmd_valid, cmd_pop;
    cmd_t cmd;
    res_t res;

    // command intake
    stq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_data   (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // list engine
    stq_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (m_tvalid),
        .out       (res),
        .out_ready (m_tready)
    );

    // result beat packing
    assign m_tuser = res.kind;
    assign m_tlast = res.last;
    assign m_tdata = {6'd0, res.queue, res.data, res.slot, res.status};

endmodule
